// ===== hw/rtl/icfp_pkg.sv =====
// icfp_pkg: shared constants and types for the impedance command frame packer
// no dependencies; imported by icfp_quantizer and impedance_command_frame_packer
package icfp_pkg;

    localparam int DATA_W          = 32;
    localparam int POS_CODE_BITS   = 16;
    localparam int OTHER_CODE_BITS = 12;
    // quotient width of the divider, one bit per stage
    localparam int QUOT_BITS       = 16;
    // clamp stage, numerator stage, then one stage per quotient bit
    localparam int Q_STAGES        = 2 + QUOT_BITS;
    // quantizer stages plus the output register
    localparam int PIPE_DEPTH      = Q_STAGES + 1;
    localparam int FRAME_W         = POS_CODE_BITS + 4 * OTHER_CODE_BITS;
    localparam int REG_COUNT       = 8;
    localparam int REG_IDX_W       = $clog2(REG_COUNT);
    localparam int ADDR_W          = REG_IDX_W + 2;

    localparam logic signed [DATA_W-1:0] STIFFNESS_FLOOR_DEF = '0;
    localparam logic signed [DATA_W-1:0] DAMPING_FLOOR_DEF   = '0;

    localparam logic signed [DATA_W-1:0] POSITION_LOW_RST   = -32'sd819200;
    localparam logic signed [DATA_W-1:0] POSITION_HIGH_RST  = 32'sd819200;
    localparam logic signed [DATA_W-1:0] VELOCITY_LOW_RST   = -32'sd2949120;
    localparam logic signed [DATA_W-1:0] VELOCITY_HIGH_RST  = 32'sd2949120;
    localparam logic signed [DATA_W-1:0] STIFFNESS_HIGH_RST = 32'sd32768000;
    localparam logic signed [DATA_W-1:0] DAMPING_HIGH_RST   = 32'sd327680;
    localparam logic signed [DATA_W-1:0] TORQUE_LOW_RST     = -32'sd1179648;
    localparam logic signed [DATA_W-1:0] TORQUE_HIGH_RST    = 32'sd1179648;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_POSITION_LOW   = 3'd0,
        REG_POSITION_HIGH  = 3'd1,
        REG_VELOCITY_LOW   = 3'd2,
        REG_VELOCITY_HIGH  = 3'd3,
        REG_STIFFNESS_HIGH = 3'd4,
        REG_DAMPING_HIGH   = 3'd5,
        REG_TORQUE_LOW     = 3'd6,
        REG_TORQUE_HIGH    = 3'd7
    } reg_index_t;

endpackage

// ===== hw/rtl/icfp_quantizer.sv =====
// icfp_quantizer: clamp, scale and pipelined restoring divide for one field
// depends on icfp_pkg; stage enables come from the top-level flow control
module icfp_quantizer
    import icfp_pkg::*;
#(
    parameter int CODE_BITS = OTHER_CODE_BITS
)
(
    input  logic                     clk,
    input  logic [Q_STAGES-1:0]      stage_en,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] low,
    input  logic signed [DATA_W-1:0] high,
    output logic [CODE_BITS-1:0]     code,
    output logic                     fault
);

    localparam int PAD   = QUOT_BITS - CODE_BITS;
    localparam int NUM_W = DATA_W + QUOT_BITS;

    // clamp stage
    logic signed [DATA_W-1:0] clamped;
    logic signed [DATA_W:0]   off_diff;
    logic signed [DATA_W:0]   span_diff;
    logic                     range_bad;
    logic [DATA_W-1:0]        off_reg;
    logic [DATA_W-1:0]        span_reg;
    logic                     flt0_reg;

    always_comb
    begin
        range_bad = (high <= low);
        if (value < low)
        begin
            clamped = low;
        end
        else if (value > high)
        begin
            clamped = high;
        end
        else
        begin
            clamped = value;
        end
        off_diff  = {clamped[DATA_W-1], clamped} - {low[DATA_W-1], low};
        span_diff = {high[DATA_W-1], high} - {low[DATA_W-1], low};
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            // an empty range divides zero by one, so its code is zero
            off_reg  <= range_bad ? '0 : off_diff[DATA_W-1:0];
            span_reg <= range_bad ? DATA_W'(1) : span_diff[DATA_W-1:0];
            flt0_reg <= range_bad;
        end
    end

    // numerator stage: off * (2^b - 1), aligned to the 16-bit quotient
    logic [NUM_W-1:0] off_wide;
    logic [NUM_W-1:0] num;

    always_comb
    begin
        off_wide = NUM_W'(off_reg);
        num      = ((off_wide << CODE_BITS) - off_wide) << PAD;
    end

    logic [DATA_W-1:0]    rem_reg [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] low_reg [QUOT_BITS+1];
    logic [DATA_W-1:0]    div_reg [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] quo_reg [QUOT_BITS+1];
    logic                 flt_reg [QUOT_BITS+1];

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            rem_reg[0] <= num[NUM_W-1 -: DATA_W];
            low_reg[0] <= num[QUOT_BITS-1:0];
            div_reg[0] <= span_reg;
            quo_reg[0] <= '0;
            flt_reg[0] <= flt0_reg;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < QUOT_BITS; k++)
    begin : g_div
        logic [DATA_W:0] trial;
        logic [DATA_W:0] diff;
        logic            ge;

        always_comb
        begin
            trial = {rem_reg[k], low_reg[k][QUOT_BITS-1]};
            diff  = trial - {1'b0, div_reg[k]};
            ge    = (trial >= {1'b0, div_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[k+2])
            begin
                rem_reg[k+1] <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
                low_reg[k+1] <= {low_reg[k][QUOT_BITS-2:0], 1'b0};
                div_reg[k+1] <= div_reg[k];
                quo_reg[k+1] <= {quo_reg[k][QUOT_BITS-2:0], ge};
                flt_reg[k+1] <= flt_reg[k];
            end
        end
    end

    assign code  = quo_reg[QUOT_BITS][QUOT_BITS-1 -: CODE_BITS];
    assign fault = flt_reg[QUOT_BITS];

endmodule

// ===== hw/rtl/impedance_command_frame_packer.sv =====
// impedance_command_frame_packer: top level, apb registers, flow control, frame pack
// depends on icfp_pkg and icfp_quantizer
//
// takes one impedance command per transaction (position, velocity, stiffness,
// damping, feed-forward torque, all signed q16.16), clamps each value to its
// configured range, quantizes it as floor((v - low) * (2^b - 1) / (high - low))
// with b = 16 for position and 12 for the others, and packs the five codes
// big-endian into one 64-bit frame word. a range whose high is not above its
// low gives code zero and raises limit_fault. the block accepts one command
// per clock while the output is not held; each command passes through one
// clamp stage, one numerator stage, sixteen restoring divider stages (one
// quotient bit each) and the output register. every stage holds its own valid
// bit and moves up only into an empty or advancing slot, so a stall on the
// output side fills bubbles first and in_ready drops only when every stage is
// full and the output is held. the registers sit on an apb port at byte
// address 4 * index and must only be written while no command is in flight.
module impedance_command_frame_packer
    import icfp_pkg::*;
#(
    parameter logic signed [DATA_W-1:0] STIFFNESS_FLOOR = STIFFNESS_FLOOR_DEF,
    parameter logic signed [DATA_W-1:0] DAMPING_FLOOR   = DAMPING_FLOOR_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // apb configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,

    // command input
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] target_position,
    input  logic signed [DATA_W-1:0] target_velocity,
    input  logic signed [DATA_W-1:0] stiffness_gain,
    input  logic signed [DATA_W-1:0] damping_gain,
    input  logic signed [DATA_W-1:0] feedforward_torque,

    // frame output
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [FRAME_W-1:0]       frame_word,
    output logic                     limit_fault
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] position_low_reg;
    logic signed [DATA_W-1:0] position_high_reg;
    logic signed [DATA_W-1:0] velocity_low_reg;
    logic signed [DATA_W-1:0] velocity_high_reg;
    logic signed [DATA_W-1:0] stiffness_high_reg;
    logic signed [DATA_W-1:0] damping_high_reg;
    logic signed [DATA_W-1:0] torque_low_reg;
    logic signed [DATA_W-1:0] torque_high_reg;

    reg_index_t reg_idx;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = reg_index_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_low_reg   <= POSITION_LOW_RST;
            position_high_reg  <= POSITION_HIGH_RST;
            velocity_low_reg   <= VELOCITY_LOW_RST;
            velocity_high_reg  <= VELOCITY_HIGH_RST;
            stiffness_high_reg <= STIFFNESS_HIGH_RST;
            damping_high_reg   <= DAMPING_HIGH_RST;
            torque_low_reg     <= TORQUE_LOW_RST;
            torque_high_reg    <= TORQUE_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_POSITION_LOW:   position_low_reg   <= pwdata;
                REG_POSITION_HIGH:  position_high_reg  <= pwdata;
                REG_VELOCITY_LOW:   velocity_low_reg   <= pwdata;
                REG_VELOCITY_HIGH:  velocity_high_reg  <= pwdata;
                REG_STIFFNESS_HIGH: stiffness_high_reg <= pwdata;
                REG_DAMPING_HIGH:   damping_high_reg   <= pwdata;
                REG_TORQUE_LOW:     torque_low_reg     <= pwdata;
                REG_TORQUE_HIGH:    torque_high_reg    <= pwdata;
                default:            ;
            endcase
        end
    end

    // read-back mux
    always_comb
    begin
        unique case (reg_idx)
            REG_POSITION_LOW:   prdata = position_low_reg;
            REG_POSITION_HIGH:  prdata = position_high_reg;
            REG_VELOCITY_LOW:   prdata = velocity_low_reg;
            REG_VELOCITY_HIGH:  prdata = velocity_high_reg;
            REG_STIFFNESS_HIGH: prdata = stiffness_high_reg;
            REG_DAMPING_HIGH:   prdata = damping_high_reg;
            REG_TORQUE_LOW:     prdata = torque_low_reg;
            REG_TORQUE_HIGH:    prdata = torque_high_reg;
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    // a stage loads when it is empty or the stage after it loads,
    // so bubbles collapse under an output stall
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] stage_en;

    always_comb
    begin
        stage_en[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || out_ready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign in_ready = stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                if (stage_en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // per-field quantizers
    // ------------------------------------------------------------------
    logic [POS_CODE_BITS-1:0]   pos_code;
    logic [OTHER_CODE_BITS-1:0] vel_code;
    logic [OTHER_CODE_BITS-1:0] kp_code;
    logic [OTHER_CODE_BITS-1:0] kd_code;
    logic [OTHER_CODE_BITS-1:0] trq_code;
    logic [4:0]                 field_fault;

    icfp_quantizer #(.CODE_BITS(POS_CODE_BITS)) u_pos
    (
        .clk      (clk),
        .stage_en (stage_en[Q_STAGES-1:0]),
        .value    (target_position),
        .low      (position_low_reg),
        .high     (position_high_reg),
        .code     (pos_code),
        .fault    (field_fault[0])
    );

    icfp_quantizer #(.CODE_BITS(OTHER_CODE_BITS)) u_vel
    (
        .clk      (clk),
        .stage_en (stage_en[Q_STAGES-1:0]),
        .value    (target_velocity),
        .low      (velocity_low_reg),
        .high     (velocity_high_reg),
        .code     (vel_code),
        .fault    (field_fault[1])
    );

    // gain minimums are build-time constants
    icfp_quantizer #(.CODE_BITS(OTHER_CODE_BITS)) u_kp
    (
        .clk      (clk),
        .stage_en (stage_en[Q_STAGES-1:0]),
        .value    (stiffness_gain),
        .low      (STIFFNESS_FLOOR),
        .high     (stiffness_high_reg),
        .code     (kp_code),
        .fault    (field_fault[2])
    );

    icfp_quantizer #(.CODE_BITS(OTHER_CODE_BITS)) u_kd
    (
        .clk      (clk),
        .stage_en (stage_en[Q_STAGES-1:0]),
        .value    (damping_gain),
        .low      (DAMPING_FLOOR),
        .high     (damping_high_reg),
        .code     (kd_code),
        .fault    (field_fault[3])
    );

    icfp_quantizer #(.CODE_BITS(OTHER_CODE_BITS)) u_trq
    (
        .clk      (clk),
        .stage_en (stage_en[Q_STAGES-1:0]),
        .value    (feedforward_torque),
        .low      (torque_low_reg),
        .high     (torque_high_reg),
        .code     (trq_code),
        .fault    (field_fault[4])
    );

    // ------------------------------------------------------------------
    // output register: big-endian pack, position code in the top bits
    // ------------------------------------------------------------------
    logic [FRAME_W-1:0] frame_reg;
    logic               fault_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[PIPE_DEPTH-1])
        begin
            frame_reg <= {pos_code, vel_code, kp_code, kd_code, trq_code};
            fault_reg <= |field_fault;
        end
    end

    assign out_valid   = valid_reg[PIPE_DEPTH-1];
    assign frame_word  = frame_reg;
    assign limit_fault = fault_reg;

`ifndef ASSERT_OFF
    // input back-pressure only when every stage is full and the output is held
    a_ready_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg) && !out_ready)
        else $error("in_ready low while pipeline has room");

    // a frame appears only from a valid item in the last divider stage
    a_out_from_pipe : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(valid_reg[PIPE_DEPTH-2]))
        else $error("frame valid without a preceding pipeline item");

    // an accepted command always occupies the first stage next cycle
    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted transaction lost at pipeline entry");
`endif

endmodule
